FILE: rtl/hcx_pkg.sv
// Shared types and constants for the header check and XOR key prefix block.
// No dependencies; every other file imports this package.
package hcx_pkg;

  // Header and keyed-prefix geometry
  localparam int unsigned HdrLen   = 16;
  localparam int unsigned KeyedLen = 16;
  localparam int unsigned PosW     = 6;   // holds 0..32
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [PosW-1:0] PosHdr = PosW'(HdrLen);
  localparam logic [PosW-1:0] PosSat = PosW'(HdrLen + KeyedLen);

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd1;

  // 16 key bytes, byte i at bits 8i+7..8i
  typedef logic [15:0][7:0] key_t;

  // Fixed file signature, byte 0 in the low bits
  localparam key_t SIG = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h56, 8'h4D, 8'h47, 8'h50, 8'h52
  };

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SHORT    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       out_last;
  } out_word_t;

endpackage

FILE: rtl/header_check_xor_deobfuscator_top.sv
// Header check and XOR key prefix strip. Takes one file byte per word, with
// a last flag. The 16-byte signature is checked and swallowed; the next 16
// bytes are XORed with the 128-bit key, later bytes pass unchanged. Status
// words report a short file, a bad header or an empty payload. One input
// word per cycle; each result is held in the result register, and the
// input stalls only while a held result is itself stalled downstream.
// Depends on hcx_pkg, hcx_cfg, hcx_core and hcx_outreg.
module header_check_xor_deobfuscator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hcx_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hcx_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hcx_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hcx_pkg::CfgDataW-1:0]  cfg_data
);
  import hcx_pkg::*;

  key_t      key;
  logic      acc;
  logic      res_valid;
  out_word_t res;
  logic      busy;

  assign in_stall = busy;
  assign acc      = in_valid & ~busy;

  hcx_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  hcx_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_word   (in_data),
    .key       (key),
    .res_valid (res_valid),
    .res       (res)
  );

  hcx_outreg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc & res_valid),
    .res       (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/hcx_cfg.sv
// Key register file: two 64-bit halves of the 128-bit XOR key.
// Depends on hcx_pkg.
module hcx_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hcx_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hcx_pkg::CfgDataW-1:0]  cfg_data,
  output hcx_pkg::key_t                 key
);
  import hcx_pkg::*;

  key_t key_r;

  // Writes always taken; unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegKeyLow:  key_r[7:0]  <= cfg_data;
        RegKeyHigh: key_r[15:8] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign key = key_r;

endmodule

FILE: rtl/hcx_core.sv
// Per-file state: byte count, header check and keyed XOR of the prefix.
// Depends on hcx_pkg; produces at most one result word per input word.
module hcx_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  hcx_pkg::in_word_t in_word,
  input  hcx_pkg::key_t     key,
  output logic              res_valid,
  output hcx_pkg::out_word_t res
);
  import hcx_pkg::*;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic            bad_r, bad_nxt;
  logic            disc_r, disc_nxt;
  logic            bad_now;

  // Next state and result for the word on the input
  always_comb begin
    pos_nxt   = pos_r;
    bad_nxt   = bad_r;
    disc_nxt  = disc_r;
    res_valid = 1'b0;
    res       = '{out_byte: 8'h00, status: ST_DATA, out_last: 1'b1};
    bad_now   = bad_r | (in_word.in_byte != SIG[pos_r[3:0]]);

    if (disc_r) begin
      // dropping the rest of a bad file
      if (in_word.in_last) begin
        pos_nxt  = '0;
        bad_nxt  = 1'b0;
        disc_nxt = 1'b0;
      end
    end else if (pos_r < PosHdr) begin
      if (pos_r != PosHdr - PosW'(1)) begin
        // inside the header
        if (in_word.in_last) begin
          pos_nxt    = '0;
          bad_nxt    = 1'b0;
          res_valid  = 1'b1;
          res.status = ST_SHORT;
        end else begin
          pos_nxt = pos_r + PosW'(1);
          bad_nxt = bad_now;
        end
      end else begin
        // final header byte: verdict
        res_valid = bad_now | in_word.in_last;
        bad_nxt   = 1'b0;
        if (bad_now) begin
          res.status = ST_MISMATCH;
        end else begin
          res.status = ST_EMPTY;
        end
        if (in_word.in_last) begin
          pos_nxt = '0;
        end else begin
          pos_nxt  = PosHdr;
          disc_nxt = bad_now;
        end
      end
    end else begin
      // payload: XOR the keyed prefix, pass the rest
      res_valid    = 1'b1;
      res.status   = ST_DATA;
      res.out_last = in_word.in_last;
      if (pos_r < PosSat) begin
        res.out_byte = in_word.in_byte ^ key[pos_r[3:0]];
        pos_nxt      = pos_r + PosW'(1);
      end else begin
        res.out_byte = in_word.in_byte;
      end
      if (in_word.in_last) begin
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      bad_r  <= 1'b0;
      disc_r <= 1'b0;
    end else if (acc) begin
      pos_r  <= pos_nxt;
      bad_r  <= bad_nxt;
      disc_r <= disc_nxt;
    end
  end

  // Count never passes saturation
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= PosSat)
    else $error("byte count beyond saturation");
  // Discarding only ever follows a full header
  a_disc_pos: assert property (@(posedge clk) disable iff (!rst_n) disc_r |-> pos_r == PosHdr)
    else $error("discarding without a complete header");
  // Mismatch flag is spent once the verdict is given
  a_disc_bad: assert property (@(posedge clk) disable iff (!rst_n) disc_r |-> !bad_r)
    else $error("mismatch flag held while discarding");

endmodule

FILE: rtl/hcx_outreg.sv
// Result register between the core and the output channel.
// Depends on hcx_pkg; stalls the input only while a held word is blocked.
module hcx_outreg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  hcx_pkg::out_word_t res,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output hcx_pkg::out_word_t out_data
);
  import hcx_pkg::*;

  logic      vld_r, vld_nxt;
  out_word_t data_r;

  // Full and not draining this cycle
  assign busy = vld_r & out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

FILE: tb/sv/header_check_xor_deobfuscator_top_tb.sv
// Testbench for the header check and XOR key prefix block: files of bytes go in,
// a local predictor computes the stripped and unmasked words, every result is checked.
// Depends on hcx_pkg and header_check_xor_deobfuscator_top.
module header_check_xor_deobfuscator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcx_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused  = 2'd2;  // index with no register behind it
  localparam int unsigned        HoldCycles = 200;   // long receiver hold-off
  localparam int unsigned        IdleLimit  = 2000;  // watchdog, cycles with no handshake
  localparam int unsigned        DrainWait  = 4;     // settle time after the last result

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Predictor state
  logic [CfgDataW-1:0] key_low_q  = '0;
  logic [CfgDataW-1:0] key_high_q = '0;
  logic [PosW-1:0]     file_pos   = '0;
  bit                  sig_bad    = 1'b0;
  bit                  dropping   = 1'b0;
  out_word_t           plain_words_q[$];

  // Stimulus control and statistics
  logic [7:0]  file_q[$];
  bit          gaps_on  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned words_in     = 0;
  int unsigned results_seen = 0;
  int unsigned files_sent   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  header_check_xor_deobfuscator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void restart_file();
    file_pos = '0;
    sig_bad  = 1'b0;
    dropping = 1'b0;
  endfunction

  function automatic void expect_word(logic [7:0] b, status_t st, logic l);
    out_word_t r;
    r.out_byte = b;
    r.status   = st;
    r.out_last = l;
    plain_words_q.push_back(r);
  endfunction

  // One accepted input word: header check, key XOR on the prefix, pass-through after
  function automatic void strip_and_unmask(in_word_t w);
    logic [PosW-1:0] p;
    logic [PosW-1:0] k;
    logic [7:0]      d;
    key_t            key_bytes;
    key_bytes = {key_high_q, key_low_q};
    p = file_pos;
    // rest of a file with a bad header is dropped
    if (dropping) begin
      if (w.in_last) restart_file();
      return;
    end
    // signature bytes give nothing, except a status on a short file's last byte or at the end of the header
    if (p < PosHdr) begin
      if (w.in_byte != SIG[p[3:0]]) sig_bad = 1'b1;
      p = p + PosW'(1);
      file_pos = p;
      if (p < PosHdr) begin
        if (w.in_last) begin
          restart_file();
          expect_word(8'h00, ST_SHORT, 1'b1);
        end
        return;
      end
      if (sig_bad) begin
        sig_bad = 1'b0;
        if (w.in_last) restart_file();
        else dropping = 1'b1;
        expect_word(8'h00, ST_MISMATCH, 1'b1);
        return;
      end
      if (w.in_last) begin
        restart_file();
        expect_word(8'h00, ST_EMPTY, 1'b1);
      end
      return;
    end
    // payload: the first KeyedLen bytes are masked by the key
    k = p - PosHdr;
    d = w.in_byte;
    if (k < PosW'(KeyedLen)) d = w.in_byte ^ key_bytes[k[3:0]];
    if (p < PosSat) file_pos = p + PosW'(1);
    if (w.in_last) restart_file();
    expect_word(d, ST_DATA, w.in_last);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: results first, then the input word and register writes of this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t exp_w;
    bit        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_seen++;
        status_seen[out_data.status]++;
        if (plain_words_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word byte=%h status=%0d last=%b", $realtime,
                   out_data.out_byte, out_data.status, out_data.out_last);
        end else begin
          exp_w = plain_words_q.pop_front();
          if (out_data.out_byte !== exp_w.out_byte) begin
            mismatches++;
            $display("%0t: out_byte expected %h, got %h", $realtime,
                     exp_w.out_byte, out_data.out_byte);
          end
          if (out_data.status !== exp_w.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $realtime,
                     exp_w.status, out_data.status);
          end
          if (out_data.out_last !== exp_w.out_last) begin
            mismatches++;
            $display("%0t: out_last expected %b, got %b", $realtime,
                     exp_w.out_last, out_data.out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        words_in++;
        strip_and_unmask(in_data);
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          RegKeyLow:  key_low_q  = cfg_data;
          RegKeyHigh: key_high_q = cfg_data;
          default: ;
        endcase
      end
    end
    // watchdog
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $realtime,
               IdleLimit, plain_words_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or one long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 25);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // one word, with an optional idle gap in front of it
  task automatic send_word(input logic [7:0] b, input logic l);
    if (gaps_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.in_byte <= b;
    in_data.in_last <= l;
    do @(posedge clk); while (in_stall);
  endtask

  // sends file_q, last flag on its final byte
  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_word(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  // first n signature bytes, one of them corrupted when bad_at is in range
  task automatic put_signature(input int n, input int bad_at);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = SIG[i];
      if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      file_q.push_back(b);
    end
  endtask

  task automatic put_random(input int n);
    repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // sender pauses until every expected word is back and the block has settled
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (plain_words_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_key(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi);
    cfg_write(RegKeyLow, lo);
    cfg_write(RegKeyHigh, hi);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // last flag before the header is complete, with good and bad signature bytes
  task automatic test_short_files();
    file_q.delete(); file_q.push_back(8'h00);   send_file();
    file_q.delete(); put_signature(1, -1);      send_file();
    file_q.delete(); put_signature(15, -1);     send_file();
    file_q.delete(); put_signature(15, 3);      send_file();
    wait_results_drained();
  endtask

  // good header, 16th byte flagged last
  task automatic test_empty_payload();
    file_q.delete(); put_signature(16, -1); send_file();
    wait_results_drained();
  endtask

  // bad signature: status once, tail dropped, next file decoded normally
  task automatic test_header_mismatch();
    file_q.delete(); put_signature(16, 0);  send_file();
    file_q.delete(); put_signature(16, 15); put_random(3); send_file();
    file_q.delete(); put_signature(16, 7);  put_random(1); send_file();
    file_q.delete(); put_signature(16, -1); put_random(1); send_file();
    wait_results_drained();
  endtask

  // key extremes across the masked prefix, its boundary and the saturated count
  task automatic test_keyed_prefix();
    load_key('1, '0);
    file_q.delete(); put_signature(16, -1);
    for (int i = 0; i < 40; i++) file_q.push_back(i[0] ? 8'hFF : 8'h00);
    send_file();
    wait_results_drained();
    load_key('0, '1);
    file_q.delete(); put_signature(16, -1); put_random(17); send_file();
    wait_results_drained();
    // a write to an unused index must leave the key alone
    cfg_write(RegUnused, '1);
    cfg_valid <= 1'b0;
    file_q.delete(); put_signature(16, -1); put_random(16); send_file();
    wait_results_drained();
    load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    file_q.delete(); put_signature(16, -1); put_random(32); send_file();
    wait_results_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    file_q.delete(); put_signature(16, -1); put_random(30); send_file();
    wait_results_drained();
  endtask

  // mostly well-formed files with random payloads, some corrupt or short ones
  task automatic test_random_files(input int unsigned target);
    int unsigned sent;
    int unsigned kind;
    int unsigned plen;
    sent = 0;
    while (sent < target) begin
      file_q.delete();
      kind = $urandom_range(99);
      if (kind < 75) begin
        plen = ($urandom_range(9) != 0) ? $urandom_range(0, 40) : $urandom_range(41, 120);
        put_signature(16, -1);
        put_random(plen);
        sent += 16 + plen;
      end else if (kind < 87) begin
        put_signature(16, $urandom_range(0, 15));
        put_random($urandom_range(0, 8));
        sent += file_q.size();
      end else if (kind < 93) begin
        put_signature($urandom_range(1, 15), -1);
        sent += file_q.size();
      end else begin
        put_random($urandom_range(1, 15));
        sent += file_q.size();
      end
      send_file();
    end
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key of zero first
    test_short_files();
    test_empty_payload();
    test_header_mismatch();
    test_keyed_prefix();
    test_backpressure();

    load_key({$urandom, $urandom}, {$urandom, $urandom});
    test_random_files(120);
    load_key('1, '1);
    test_random_files(90);
    // quiet stretch: no idling on either side
    gaps_on = 1'b0;
    load_key({$urandom, $urandom}, '0);
    test_random_files(120);
    gaps_on = 1'b1;
    load_key('0, {$urandom, $urandom});
    test_random_files(140);

    $display("Covered %0d files, %0d words in, %0d results checked", files_sent,
             words_in, results_seen);
    $display("Results by status: data %0d, mismatch %0d, short %0d, empty %0d",
             status_seen[ST_DATA], status_seen[ST_MISMATCH], status_seen[ST_SHORT],
             status_seen[ST_EMPTY]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
